// ----- rtl/sdrt_pkg.sv -----
package sdrt_pkg;

    localparam int TABLE_DEPTH = 16;
    localparam int OP_W        = 3;
    localparam int ID_W        = 27;
    localparam int PAY_W       = 31;
    localparam int STS_W       = 2;
    localparam int CNT_W       = 5;

    typedef enum logic [OP_W-1:0] {
        OP_INSERT   = 3'd0,
        OP_DEL_ID   = 3'd1,
        OP_DEL_PAY  = 3'd2,
        OP_FIND_ID  = 3'd3,
        OP_FIND_PAY = 3'd4
    } op_t;

    typedef enum logic [STS_W-1:0] {
        STS_OK        = 2'd0,
        STS_NOT_FOUND = 2'd1,
        STS_DUP       = 2'd2,
        STS_FULL      = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_SCAN
    } fsm_t;

    typedef enum logic [2:0] {
        ACT_HOLD,
        ACT_INSERT,
        ACT_DROP,
        ACT_MARK,
        ACT_CLEAR
    } act_t;

    typedef enum logic [1:0] {
        SEL_NONE,
        SEL_ID,
        SEL_PAY,
        SEL_MARK
    } sel_t;

    typedef struct packed {
        logic             valid;
        logic [ID_W-1:0]  id;
        logic [PAY_W-1:0] pay;
    } entry_t;

    typedef struct packed {
        act_t             act;
        sel_t             sel;
        logic [ID_W-1:0]  key_id;
        logic [PAY_W-1:0] key_pay;
    } cell_cmd_t;

    typedef struct packed {
        logic valid;
        logic id_hit;
        logic pay_hit;
        logic first;
        logic rest;
    } cell_flag_t;

endpackage

// ----- rtl/sdrt_cell.sv -----
module sdrt_cell (
    input  logic                clk,
    input  logic                rst_n,
    input  sdrt_pkg::cell_cmd_t cmd,
    input  sdrt_pkg::entry_t    left_ent,
    input  sdrt_pkg::entry_t    right_ent,
    input  logic                gt_in,
    input  logic                sel_in,
    output sdrt_pkg::entry_t    ent,
    output logic                gt_out,
    output logic                sel_out,
    output sdrt_pkg::cell_flag_t flag
);

    logic                       valid_reg;
    logic                       valid_next;
    logic                       mark_reg;
    logic                       mark_next;
    logic [sdrt_pkg::ID_W-1:0]  id_reg;
    logic [sdrt_pkg::ID_W-1:0]  id_next;
    logic [sdrt_pkg::PAY_W-1:0] pay_reg;
    logic [sdrt_pkg::PAY_W-1:0] pay_next;
    logic                       id_hit;
    logic                       pay_hit;
    logic                       gt;
    logic                       sel_local;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            mark_reg  <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
            mark_reg  <= mark_next;
        end
    end

    always_ff @(posedge clk)
    begin
        id_reg  <= id_next;
        pay_reg <= pay_next;
    end

    always_comb
    begin
        id_hit  = valid_reg && (id_reg == cmd.key_id);
        pay_hit = valid_reg && (pay_reg == cmd.key_pay);
        gt      = valid_reg && (pay_reg > cmd.key_pay);

        case (cmd.sel)
            sdrt_pkg::SEL_ID:   sel_local = id_hit;
            sdrt_pkg::SEL_PAY:  sel_local = pay_hit;
            sdrt_pkg::SEL_MARK: sel_local = mark_reg;
            default:            sel_local = 1'b0;
        endcase

        sel_out = sel_in | sel_local;
        gt_out  = gt;

        valid_next = valid_reg;
        mark_next  = mark_reg;
        id_next    = id_reg;
        pay_next   = pay_reg;

        case (cmd.act)
            sdrt_pkg::ACT_INSERT:
            begin
                if (!gt)
                begin
                    if (gt_in)
                    begin
                        valid_next = 1'b1;
                        id_next    = cmd.key_id;
                        pay_next   = cmd.key_pay;
                    end
                    else
                    begin
                        valid_next = left_ent.valid;
                        id_next    = left_ent.id;
                        pay_next   = left_ent.pay;
                    end
                end
            end
            sdrt_pkg::ACT_DROP:
            begin
                if (sel_out)
                begin
                    valid_next = right_ent.valid;
                    id_next    = right_ent.id;
                    pay_next   = right_ent.pay;
                end
            end
            sdrt_pkg::ACT_MARK:
            begin
                mark_next = pay_hit;
            end
            sdrt_pkg::ACT_CLEAR:
            begin
                if (sel_local && !sel_in)
                    mark_next = 1'b0;
            end
            default:
            begin
            end
        endcase

        ent.valid    = valid_reg;
        ent.id       = id_reg;
        ent.pay      = pay_reg;
        flag.valid   = valid_reg;
        flag.id_hit  = id_hit;
        flag.pay_hit = pay_hit;
        flag.first   = sel_local && !sel_in;
        flag.rest    = sel_local && sel_in;
    end

endmodule

// ----- rtl/descending_sorted_record_table_unit.sv -----
// Sorted record table held in a row of compare-and-shift cells, largest pay
// first, newest first among equal pays. A command is taken at a clock edge
// where start is high and busy is low; its results come out on done, one
// per cycle, and the receiver cannot stall them, so it must take each
// transaction in the cycle it appears. Insert, remove by id, find by id and
// unknown opcodes are captured, then complete as every cell compares and
// shifts at once. Remove by pay takes out the k matching records one at a
// time, as the cell row closes up one record per cycle. Find by pay gives
// a not-found result when nothing matches, else k results for k matches,
// one result per cycle in table order. busy drops with the last result, so the
// next command may be taken in that same cycle.
module descending_sorted_record_table_unit (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [sdrt_pkg::OP_W-1:0]     opcode,
    input  logic [sdrt_pkg::ID_W-1:0]     emp_id,
    input  logic [sdrt_pkg::PAY_W-1:0]    pay,
    output logic                          done,
    output logic [sdrt_pkg::STS_W-1:0]    status,
    output logic [sdrt_pkg::ID_W-1:0]     found_id,
    output logic [sdrt_pkg::PAY_W-1:0]    found_pay,
    output logic [sdrt_pkg::CNT_W-1:0]    removed_count,
    output logic                          last_item
);

    localparam int DEPTH = sdrt_pkg::TABLE_DEPTH;

    sdrt_pkg::fsm_t             state_reg;
    sdrt_pkg::fsm_t             state_next;
    logic [sdrt_pkg::OP_W-1:0]  op_reg;
    logic [sdrt_pkg::OP_W-1:0]  op_next;
    logic [sdrt_pkg::ID_W-1:0]  key_id_reg;
    logic [sdrt_pkg::ID_W-1:0]  key_id_next;
    logic [sdrt_pkg::PAY_W-1:0] key_pay_reg;
    logic [sdrt_pkg::PAY_W-1:0] key_pay_next;
    logic [sdrt_pkg::CNT_W-1:0] count_reg;
    logic [sdrt_pkg::CNT_W-1:0] count_next;
    logic                       done_reg;
    logic                       done_next;
    logic [sdrt_pkg::STS_W-1:0] status_reg;
    logic [sdrt_pkg::STS_W-1:0] status_next;
    logic [sdrt_pkg::ID_W-1:0]  found_id_reg;
    logic [sdrt_pkg::ID_W-1:0]  found_id_next;
    logic [sdrt_pkg::PAY_W-1:0] found_pay_reg;
    logic [sdrt_pkg::PAY_W-1:0] found_pay_next;
    logic [sdrt_pkg::CNT_W-1:0] removed_reg;
    logic [sdrt_pkg::CNT_W-1:0] removed_next;
    logic                       last_reg;
    logic                       last_next;

    sdrt_pkg::cell_cmd_t        cmd;
    sdrt_pkg::entry_t           ent      [DEPTH];
    sdrt_pkg::entry_t           left_ent [DEPTH];
    sdrt_pkg::entry_t           right_ent[DEPTH];
    sdrt_pkg::cell_flag_t       flag     [DEPTH];
    logic [DEPTH:0]             gt_c;
    logic [DEPTH:0]             sel_c;
    logic [DEPTH-1:0]           valid_vec;
    logic                       id_any;
    logic                       pay_any;
    logic                       more;
    logic                       full;
    logic [sdrt_pkg::ID_W-1:0]  sel_id;
    logic [sdrt_pkg::PAY_W-1:0] sel_pay;

    assign gt_c[0]  = 1'b1;
    assign sel_c[0] = 1'b0;

    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        if (i == 0)
        begin : g_head
            assign left_ent[i] = '0;
        end
        else
        begin : g_body
            assign left_ent[i] = ent[i-1];
        end

        if (i == DEPTH - 1)
        begin : g_tail
            assign right_ent[i] = '0;
        end
        else
        begin : g_mid
            assign right_ent[i] = ent[i+1];
        end

        sdrt_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .cmd       (cmd),
            .left_ent  (left_ent[i]),
            .right_ent (right_ent[i]),
            .gt_in     (gt_c[i]),
            .sel_in    (sel_c[i]),
            .ent       (ent[i]),
            .gt_out    (gt_c[i+1]),
            .sel_out   (sel_c[i+1]),
            .flag      (flag[i])
        );
    end

    always_comb
    begin
        id_any  = 1'b0;
        pay_any = 1'b0;
        more    = 1'b0;
        sel_id  = '0;
        sel_pay = '0;
        for (int i = 0; i < DEPTH; i++)
        begin
            valid_vec[i] = flag[i].valid;
            id_any       = id_any | flag[i].id_hit;
            pay_any      = pay_any | flag[i].pay_hit;
            more         = more | flag[i].rest;
            sel_id       = sel_id | (flag[i].first ? ent[i].id : '0);
            sel_pay      = sel_pay | (flag[i].first ? ent[i].pay : '0);
        end
        full = flag[DEPTH-1].valid;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= sdrt_pkg::S_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg        <= op_next;
        key_id_reg    <= key_id_next;
        key_pay_reg   <= key_pay_next;
        count_reg     <= count_next;
        status_reg    <= status_next;
        found_id_reg  <= found_id_next;
        found_pay_reg <= found_pay_next;
        removed_reg   <= removed_next;
        last_reg      <= last_next;
    end

    always_comb
    begin
        state_next     = state_reg;
        op_next        = op_reg;
        key_id_next    = key_id_reg;
        key_pay_next   = key_pay_reg;
        count_next     = count_reg;
        done_next      = 1'b0;
        status_next    = sdrt_pkg::STS_OK;
        found_id_next  = '0;
        found_pay_next = '0;
        removed_next   = '0;
        last_next      = 1'b1;
        cmd.act        = sdrt_pkg::ACT_HOLD;
        cmd.sel        = sdrt_pkg::SEL_NONE;
        cmd.key_id     = key_id_reg;
        cmd.key_pay    = key_pay_reg;

        case (state_reg)
            sdrt_pkg::S_IDLE:
            begin
                if (start)
                begin
                    op_next      = opcode;
                    key_id_next  = emp_id;
                    key_pay_next = pay;
                    count_next   = '0;
                    state_next   = sdrt_pkg::S_EXEC;
                end
            end
            sdrt_pkg::S_EXEC:
            begin
                case (op_reg)
                    sdrt_pkg::OP_INSERT:
                    begin
                        done_next  = 1'b1;
                        state_next = sdrt_pkg::S_IDLE;
                        if (id_any)
                            status_next = sdrt_pkg::STS_DUP;
                        else if (full)
                            status_next = sdrt_pkg::STS_FULL;
                        else
                            cmd.act = sdrt_pkg::ACT_INSERT;
                    end
                    sdrt_pkg::OP_DEL_ID:
                    begin
                        cmd.act    = sdrt_pkg::ACT_DROP;
                        cmd.sel    = sdrt_pkg::SEL_ID;
                        done_next  = 1'b1;
                        state_next = sdrt_pkg::S_IDLE;
                        if (id_any)
                            removed_next = sdrt_pkg::CNT_W'(1);
                        else
                            status_next = sdrt_pkg::STS_NOT_FOUND;
                    end
                    sdrt_pkg::OP_DEL_PAY:
                    begin
                        cmd.sel = sdrt_pkg::SEL_PAY;
                        if (pay_any)
                        begin
                            cmd.act    = sdrt_pkg::ACT_DROP;
                            count_next = count_reg + sdrt_pkg::CNT_W'(1);
                        end
                        else
                        begin
                            done_next    = 1'b1;
                            state_next   = sdrt_pkg::S_IDLE;
                            removed_next = count_reg;
                            if (count_reg == '0)
                                status_next = sdrt_pkg::STS_NOT_FOUND;
                        end
                    end
                    sdrt_pkg::OP_FIND_ID:
                    begin
                        cmd.sel    = sdrt_pkg::SEL_ID;
                        done_next  = 1'b1;
                        state_next = sdrt_pkg::S_IDLE;
                        if (id_any)
                        begin
                            found_id_next  = sel_id;
                            found_pay_next = sel_pay;
                        end
                        else
                            status_next = sdrt_pkg::STS_NOT_FOUND;
                    end
                    sdrt_pkg::OP_FIND_PAY:
                    begin
                        cmd.act = sdrt_pkg::ACT_MARK;
                        if (pay_any)
                            state_next = sdrt_pkg::S_SCAN;
                        else
                        begin
                            done_next   = 1'b1;
                            status_next = sdrt_pkg::STS_NOT_FOUND;
                            state_next  = sdrt_pkg::S_IDLE;
                        end
                    end
                    default:
                    begin
                        done_next   = 1'b1;
                        status_next = sdrt_pkg::STS_NOT_FOUND;
                        state_next  = sdrt_pkg::S_IDLE;
                    end
                endcase
            end
            sdrt_pkg::S_SCAN:
            begin
                cmd.act        = sdrt_pkg::ACT_CLEAR;
                cmd.sel        = sdrt_pkg::SEL_MARK;
                done_next      = 1'b1;
                found_id_next  = sel_id;
                found_pay_next = sel_pay;
                last_next      = !more;
                if (!more)
                    state_next = sdrt_pkg::S_IDLE;
            end
            default:
            begin
                state_next = sdrt_pkg::S_IDLE;
            end
        endcase
    end

    assign busy          = (state_reg != sdrt_pkg::S_IDLE);
    assign done          = done_reg;
    assign status        = status_reg;
    assign found_id      = found_id_reg;
    assign found_pay     = found_pay_reg;
    assign removed_count = removed_reg;
    assign last_item     = last_reg;

    a_valid_prefix: assert property (@(posedge clk) disable iff (!rst_n)
        (valid_vec & (valid_vec + DEPTH'(1))) == '0)
        else $error("table entries are not packed toward the head");

    a_more_follows: assert property (@(posedge clk) disable iff (!rst_n)
        done && !last_item |-> busy)
        else $error("result not marked last while the unit is idle");

    a_last_frees: assert property (@(posedge clk) disable iff (!rst_n)
        done && last_item |-> !busy)
        else $error("unit still busy after the last result");

    a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> busy && !done)
        else $error("accepted command did not occupy the unit");

endmodule

// ----- test/descending_sorted_record_table_unit_tb.sv -----
module descending_sorted_record_table_unit_tb;
    import sdrt_pkg::*;

    localparam logic [ID_W-1:0]  ID_MAX          = 27'd99999999;
    localparam logic [PAY_W-1:0] PAY_MAX         = '1;
    localparam logic [OP_W-1:0]  OP_FIRST_UNUSED = OP_FIND_PAY + 1'b1;
    localparam logic [OP_W-1:0]  OP_LAST_UNUSED  = '1;
    localparam int               MAX_GAP         = 13;
    localparam int               RANDOM_ITEMS    = 93;
    localparam int               DRAIN_CYCLES    = 20;
    localparam int               PLAN_LEN        = 27;

    typedef struct {
        status_t          st;
        logic [ID_W-1:0]  id;
        logic [PAY_W-1:0] pay;
        logic [CNT_W-1:0] cnt;
        logic             last;
    } reply_t;

    typedef struct {
        logic [OP_W-1:0]  op;
        logic [ID_W-1:0]  id;
        logic [PAY_W-1:0] pay;
        bit               typed;
        status_t          st;
        logic [ID_W-1:0]  fid;
        logic [PAY_W-1:0] fpay;
        logic [CNT_W-1:0] cnt;
    } step_t;

    logic             clk = 1'b0;
    logic             rst_n = 1'b0;
    logic             start = 1'b0;
    logic [OP_W-1:0]  opcode = '0;
    logic [ID_W-1:0]  emp_id = '0;
    logic [PAY_W-1:0] pay = '0;
    logic             busy;
    logic             done;
    logic [STS_W-1:0] status;
    logic [ID_W-1:0]  found_id;
    logic [PAY_W-1:0] found_pay;
    logic [CNT_W-1:0] removed_count;
    logic             last_item;

    reply_t           pending_replies[$];
    reply_t           fresh_replies[$];
    logic [ID_W-1:0]  roster_id[TABLE_DEPTH];
    logic [PAY_W-1:0] roster_pay[TABLE_DEPTH];
    int               roster_len = 0;
    int               mismatches = 0;
    int               commands_sent = 0;
    int               replies_checked = 0;
    int               full_rejects = 0;
    int               multi_lists = 0;
    bit               quiet_run = 1'b0;

    step_t plan [PLAN_LEN] = '{
        '{OP_FIND_PAY,    0,        0,          1'b1, STS_NOT_FOUND, 0,      0,       0},
        '{OP_DEL_PAY,     0,        PAY_MAX,    1'b1, STS_NOT_FOUND, 0,      0,       0},
        '{OP_DEL_ID,      ID_MAX,   0,          1'b1, STS_NOT_FOUND, 0,      0,       0},
        '{OP_FIND_ID,     0,        0,          1'b1, STS_NOT_FOUND, 0,      0,       0},
        '{OP_LAST_UNUSED, ID_MAX,   PAY_MAX,    1'b1, STS_NOT_FOUND, 0,      0,       0},
        '{OP_INSERT,      0,        0,          1'b1, STS_OK,        0,      0,       0},
        '{OP_INSERT,      ID_MAX,   PAY_MAX,    1'b1, STS_OK,        0,      0,       0},
        '{OP_INSERT,      1,        0,          1'b1, STS_OK,        0,      0,       0},
        '{OP_INSERT,      2,        1000,       1'b1, STS_OK,        0,      0,       0},
        '{OP_INSERT,      3,        1000,       1'b1, STS_OK,        0,      0,       0},
        '{OP_INSERT,      4,        PAY_MAX,    1'b1, STS_OK,        0,      0,       0},
        '{OP_INSERT,      5,        1000,       1'b1, STS_OK,        0,      0,       0},
        '{OP_INSERT,      6,        500,        1'b1, STS_OK,        0,      0,       0},
        '{OP_INSERT,      7,        1000,       1'b1, STS_OK,        0,      0,       0},
        '{OP_INSERT,      8,        1,          1'b1, STS_OK,        0,      0,       0},
        '{OP_INSERT,      9,        0,          1'b1, STS_OK,        0,      0,       0},
        '{OP_INSERT,      10,       700000,     1'b1, STS_OK,        0,      0,       0},
        '{OP_INSERT,      11,       500,        1'b1, STS_OK,        0,      0,       0},
        '{OP_INSERT,      67108864, 1073741824, 1'b1, STS_OK,        0,      0,       0},
        '{OP_INSERT,      12,       2147483646, 1'b1, STS_OK,        0,      0,       0},
        '{OP_INSERT,      13,       999,        1'b1, STS_OK,        0,      0,       0},
        '{OP_INSERT,      0,        5,          1'b1, STS_DUP,       0,      0,       0},
        '{OP_INSERT,      14,       5,          1'b1, STS_FULL,      0,      0,       0},
        '{OP_FIND_PAY,    0,        1000,       1'b0, STS_OK,        0,      0,       0},
        '{OP_DEL_PAY,     0,        0,          1'b1, STS_OK,        0,      0,       3},
        '{OP_FIND_ID,     ID_MAX,   0,          1'b1, STS_OK,        ID_MAX, PAY_MAX, 0},
        '{OP_DEL_ID,      ID_MAX,   0,          1'b1, STS_OK,        0,      0,       1}
    };

    descending_sorted_record_table_unit dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .opcode        (opcode),
        .emp_id        (emp_id),
        .pay           (pay),
        .done          (done),
        .status        (status),
        .found_id      (found_id),
        .found_pay     (found_pay),
        .removed_count (removed_count),
        .last_item     (last_item)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic void reply(status_t st, logic [ID_W-1:0] id, logic [PAY_W-1:0] py,
                                  logic [CNT_W-1:0] cnt, logic last);
        reply_t r;
        r.st   = st;
        r.id   = id;
        r.pay  = py;
        r.cnt  = cnt;
        r.last = last;
        fresh_replies.push_back(r);
    endfunction

    function automatic void drop_entry(int pos);
        for (int i = pos; i + 1 < roster_len; i++)
        begin
            roster_id[i]  = roster_id[i + 1];
            roster_pay[i] = roster_pay[i + 1];
        end
        roster_len--;
    endfunction

    function automatic void roster_update(logic [OP_W-1:0] key_op, logic [ID_W-1:0] key_id,
                                          logic [PAY_W-1:0] key_pay);
        int pos;
        int removed;
        int hits;
        fresh_replies.delete();
        pos = -1;
        for (int i = 0; i < roster_len; i++)
            if (pos < 0 && roster_id[i] == key_id)
                pos = i;
        case (key_op)
            OP_INSERT:
            begin
                if (pos >= 0)
                    reply(STS_DUP, '0, '0, '0, 1'b1);
                else if (roster_len >= TABLE_DEPTH)
                begin
                    reply(STS_FULL, '0, '0, '0, 1'b1);
                    full_rejects++;
                end
                else
                begin
                    pos = 0;
                    while (pos < roster_len && roster_pay[pos] > key_pay)
                        pos++;
                    for (int i = roster_len; i > pos; i--)
                    begin
                        roster_id[i]  = roster_id[i - 1];
                        roster_pay[i] = roster_pay[i - 1];
                    end
                    roster_id[pos]  = key_id;
                    roster_pay[pos] = key_pay;
                    roster_len++;
                    reply(STS_OK, '0, '0, '0, 1'b1);
                end
            end
            OP_DEL_ID:
            begin
                if (pos < 0)
                    reply(STS_NOT_FOUND, '0, '0, '0, 1'b1);
                else
                begin
                    drop_entry(pos);
                    reply(STS_OK, '0, '0, CNT_W'(1), 1'b1);
                end
            end
            OP_DEL_PAY:
            begin
                removed = 0;
                pos = 0;
                while (pos < roster_len)
                begin
                    if (roster_pay[pos] == key_pay)
                    begin
                        drop_entry(pos);
                        removed++;
                    end
                    else
                        pos++;
                end
                reply(removed > 0 ? STS_OK : STS_NOT_FOUND, '0, '0, CNT_W'(removed), 1'b1);
            end
            OP_FIND_ID:
            begin
                if (pos < 0)
                    reply(STS_NOT_FOUND, '0, '0, '0, 1'b1);
                else
                    reply(STS_OK, roster_id[pos], roster_pay[pos], '0, 1'b1);
            end
            OP_FIND_PAY:
            begin
                hits = 0;
                for (int i = 0; i < roster_len; i++)
                    if (roster_pay[i] == key_pay)
                    begin
                        reply(STS_OK, roster_id[i], roster_pay[i], '0, 1'b0);
                        hits++;
                    end
                if (hits == 0)
                    reply(STS_NOT_FOUND, '0, '0, '0, 1'b1);
                else
                    fresh_replies[fresh_replies.size() - 1].last = 1'b1;
                if (hits > 1)
                    multi_lists++;
            end
            default:
                reply(STS_NOT_FOUND, '0, '0, '0, 1'b1);
        endcase
    endfunction

    task automatic issue(input logic [OP_W-1:0] cmd_op, input logic [ID_W-1:0] cmd_id,
                         input logic [PAY_W-1:0] cmd_pay, input bit typed, input reply_t want);
        int gap;
        gap = quiet_run ? 0 : $urandom_range(0, MAX_GAP);
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start  <= 1'b1;
        opcode <= cmd_op;
        emp_id <= cmd_id;
        pay    <= cmd_pay;
        do
            @(posedge clk);
        while (busy);
        roster_update(cmd_op, cmd_id, cmd_pay);
        commands_sent++;
        if (typed)
            pending_replies.push_back(want);
        else
            foreach (fresh_replies[k])
                pending_replies.push_back(fresh_replies[k]);
    endtask

    always @(posedge clk)
    begin : result_check
        reply_t want;
        if (rst_n && done)
        begin
            if (pending_replies.size() == 0)
            begin
                $display("%0t: unexpected transaction status %0d id %0d pay %0d count %0d last %0b",
                         $time, status, found_id, found_pay, removed_count, last_item);
                mismatches++;
            end
            else
            begin
                want = pending_replies.pop_front();
                replies_checked++;
                if (status !== want.st || found_id !== want.id || found_pay !== want.pay ||
                    removed_count !== want.cnt || last_item !== want.last)
                begin
                    $display("%0t: expected status %0d id %0d pay %0d count %0d last %0b",
                             $time, want.st, want.id, want.pay, want.cnt, want.last);
                    $display("%0t:      got status %0d id %0d pay %0d count %0d last %0b",
                             $time, status, found_id, found_pay, removed_count, last_item);
                    mismatches++;
                end
            end
        end
    end

    initial
    begin
        reply_t          want;
        int              roll;
        logic [OP_W-1:0]  op;
        logic [ID_W-1:0]  id;
        logic [PAY_W-1:0] py;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        foreach (plan[r])
        begin
            want.st   = plan[r].st;
            want.id   = plan[r].fid;
            want.pay  = plan[r].fpay;
            want.cnt  = plan[r].cnt;
            want.last = 1'b1;
            issue(plan[r].op, plan[r].id, plan[r].pay, plan[r].typed, want);
        end

        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            if (n % 16 == 0)
                quiet_run = ($urandom_range(0, 3) == 0);
            roll = $urandom_range(0, 99);
            if (roll < 40)
                op = OP_INSERT;
            else if (roll < 52)
                op = OP_DEL_ID;
            else if (roll < 60)
                op = OP_DEL_PAY;
            else if (roll < 75)
                op = OP_FIND_ID;
            else if (roll < 92)
                op = OP_FIND_PAY;
            else
                op = OP_W'($urandom_range(OP_FIRST_UNUSED, OP_LAST_UNUSED));

            roll = $urandom_range(0, 99);
            if (roster_len > 0 && roll < (op == OP_INSERT ? 8 : 40))
                id = roster_id[$urandom_range(0, roster_len - 1)];
            else if (roll < 80)
                id = ID_W'($urandom_range(0, 23));
            else if (roll < 85)
                id = ID_MAX;
            else
                id = ID_W'($urandom_range(0, ID_MAX));

            roll = $urandom_range(0, 99);
            if (roster_len > 0 && roll < 45)
                py = roster_pay[$urandom_range(0, roster_len - 1)];
            else if (roll < 75)
                py = PAY_W'($urandom_range(0, 4) * 1000);
            else if (roll < 80)
                py = '0;
            else if (roll < 85)
                py = PAY_MAX;
            else
                py = PAY_W'($urandom_range(0, PAY_MAX));

            issue(op, id, py, 1'b0, want);
        end

        start <= 1'b0;
        while (pending_replies.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("%0d commands issued, %0d result transactions checked",
                 commands_sent, replies_checked);
        $display("table-full rejects: %0d, pay lookups with several matches: %0d",
                 full_rejects, multi_lists);
        if (mismatches == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

    initial
    begin
        #500000;
        $display("simulation failed");
        $finish;
    end

endmodule
